@@ hdl/bce_pkg.sv @@
// shared types, codes and constants of the bezier curve evaluator
`default_nettype none

package bce_pkg;

  localparam int unsigned MAX_POINTS_DEF = 8;
  localparam int unsigned COORD_W        = 32;
  localparam int unsigned RATIO_W        = 17;
  localparam int unsigned NUM_AXES       = 3;
  localparam int unsigned POINT_W        = NUM_AXES * COORD_W;
  localparam int unsigned DIFF_W         = COORD_W + 1;
  localparam int unsigned PROD_W         = DIFF_W + RATIO_W + 1;
  localparam int unsigned FRAC_W         = 16;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << FRAC_W);

  // request kinds
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_EVAL   = 1'b1;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_EVAL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } bce_status_e;

  // source of the coordinates loaded into the result register
  typedef enum logic [1:0] {
    OSEL_ZERO = 2'd0,
    OSEL_RD   = 2'd1,
    OSEL_RES  = 2'd2
  } bce_osel_e;

  typedef struct packed {
    logic                      req_type;
    logic                      restart;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [RATIO_W-1:0]        ratio;
  } bce_req_t;

  typedef struct packed {
    bce_status_e               status;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
  } bce_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic        ctl_we;
    logic        wk_we;
    logic        rd_ctl;
    logic        cap_t;
    logic        cap_a;
    logic        cap_diff;
    logic        cap_prod;
    logic        shift_a;
    logic        out_load;
    bce_osel_e   out_sel;
    bce_status_e out_status;
  } bce_cmd_t;

endpackage

`default_nettype wire

@@ hdl/bce_ram.sv @@
// generic single write port memory with registered read
`default_nettype none

module bce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/bce_ctrl.sv @@
// sequencer for appends and de casteljau reduction steps
`default_nettype none

module bce_ctrl #(
  parameter int unsigned MAX_POINTS = bce_pkg::MAX_POINTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bce_pkg::bce_req_t req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bce_pkg::bce_cmd_t      cmd_o,
  output logic [(MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1)-1:0] rd_addr_o,
  output logic [(MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1)-1:0] wr_addr_o
);

  import bce_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GETA = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] lvl_q, lvl_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  logic          accept;
  logic [CW:0]   nxt_b;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // address of the b operand two places ahead of the step in flight
  assign nxt_b = {{(CW + 1 - AW){1'b0}}, idx_q} + (CW + 1)'(2);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    lvl_d     = lvl_q;
    idx_d     = idx_q;
    rd_addr_o = '0;
    wr_addr_o = '0;
    cmd_o     = '{default: '0, out_sel: OSEL_ZERO, out_status: ST_STORED};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.req_type == REQ_APPEND) begin
            cmd_o.out_load = 1'b1;
            if (req_i.restart) begin
              cmd_o.ctl_we = 1'b1;
              cnt_d        = CW'(1);
            end else if (cnt_q >= CW'(MAX_POINTS)) begin
              cmd_o.out_status = ST_FULL;
            end else begin
              cmd_o.ctl_we = 1'b1;
              wr_addr_o    = cnt_q[AW-1:0];
              cnt_d        = cnt_q + CW'(1);
            end
          end else begin
            cmd_o.cap_t = 1'b1;
            if (cnt_q == '0) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = ST_EMPTY;
            end else begin
              lvl_d   = cnt_q;
              idx_d   = '0;
              state_d = S_GETA;
            end
          end
        end
      end
      S_GETA: begin
        cmd_o.rd_ctl = (lvl_q == cnt_q);
        cmd_o.cap_a  = 1'b1;
        if (lvl_q == CW'(1)) begin
          // single point goes straight out
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_EVAL;
          cmd_o.out_sel    = OSEL_RD;
          state_d          = S_IDLE;
        end else begin
          rd_addr_o = idx_q + AW'(1);
          state_d   = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.rd_ctl   = (lvl_q == cnt_q);
        cmd_o.cap_diff = 1'b1;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.cap_prod = 1'b1;
        state_d        = S_ACC;
      end
      S_ACC: begin
        cmd_o.wk_we   = 1'b1;
        cmd_o.shift_a = 1'b1;
        wr_addr_o     = idx_q;
        if (nxt_b < {1'b0, lvl_q}) begin
          idx_d     = idx_q + AW'(1);
          rd_addr_o = nxt_b[AW-1:0];
          state_d   = S_DIFF;
        end else if (lvl_q == CW'(2)) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_EVAL;
          cmd_o.out_sel    = OSEL_RES;
          state_d          = S_IDLE;
        end else begin
          lvl_d   = lvl_q - CW'(1);
          idx_d   = '0;
          state_d = S_GETA;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lvl_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lvl_q       <= lvl_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bce_dp.sv @@
// point stores, three interpolation lanes and result register
`default_nettype none

module bce_dp #(
  parameter int unsigned MAX_POINTS = bce_pkg::MAX_POINTS_DEF
) (
  input  wire logic              clk_i,
  input  wire bce_pkg::bce_cmd_t cmd_i,
  input  wire logic [(MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1)-1:0] rd_addr_i,
  input  wire logic [(MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1)-1:0] wr_addr_i,
  input  wire bce_pkg::bce_req_t req_i,
  output bce_pkg::bce_rsp_t      rsp_o
);

  import bce_pkg::*;

  logic [POINT_W-1:0] ctl_wdata, ctl_rdata;
  logic [POINT_W-1:0] wk_wdata, wk_rdata;
  logic [POINT_W-1:0] rd_data;
  logic [RATIO_W-1:0] t_q;
  logic signed [COORD_W-1:0] res [NUM_AXES];
  logic signed [COORD_W-1:0] out_c [NUM_AXES];
  bce_rsp_t rsp_q;

  assign ctl_wdata = {req_i.point_z, req_i.point_y, req_i.point_x};
  assign wk_wdata  = {res[2], res[1], res[0]};

  bce_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_ctl_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ctl_we),
    .waddr_i (wr_addr_i),
    .wdata_i (ctl_wdata),
    .raddr_i (rd_addr_i),
    .rdata_o (ctl_rdata)
  );

  bce_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_wk_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wk_we),
    .waddr_i (wr_addr_i),
    .wdata_i (wk_wdata),
    .raddr_i (rd_addr_i),
    .rdata_o (wk_rdata)
  );

  assign rd_data = cmd_i.rd_ctl ? ctl_rdata : wk_rdata;

  // ratio saturates at one
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_t) begin
      t_q <= (req_i.ratio > RATIO_ONE) ? RATIO_ONE : req_i.ratio;
    end
  end

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
    logic signed [COORD_W-1:0] a_q, b_q, rd_c;
    logic signed [DIFF_W-1:0]  diff_q;
    logic signed [PROD_W-1:0]  prod_q;

    assign rd_c = rd_data[k*COORD_W +: COORD_W];
    // arithmetic shift of the product floors toward minus infinity
    assign res[k] = a_q + prod_q[FRAC_W +: COORD_W];

    always_ff @(posedge clk_i) begin
      if (cmd_i.cap_a) begin
        a_q <= rd_c;
      end else if (cmd_i.shift_a) begin
        a_q <= b_q;
      end
      if (cmd_i.cap_diff) begin
        b_q    <= rd_c;
        diff_q <= {rd_c[COORD_W-1], rd_c} - {a_q[COORD_W-1], a_q};
      end
      if (cmd_i.cap_prod) begin
        prod_q <= diff_q * $signed({1'b0, t_q});
      end
    end

    always_comb begin
      unique case (cmd_i.out_sel)
        OSEL_RD:  out_c[k] = rd_c;
        OSEL_RES: out_c[k] = res[k];
        default:  out_c[k] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_q.status <= cmd_i.out_status;
      rsp_q.out_x  <= out_c[0];
      rsp_q.out_y  <= out_c[1];
      rsp_q.out_z  <= out_c[2];
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

@@ hdl/bezier_curve_eval_core.sv @@
// top level of the 3-d bezier curve evaluator
`default_nettype none

// Keeps up to MAX_POINTS control points (signed Q16.16 on x, y and z) and
// evaluates the curve by de Casteljau reduction. An append request stores one
// point after the last, or as the new first point when restart is set, and
// answers status 0, or status 3 with the point dropped when the store is full.
// An evaluate request saturates the Q1.16 ratio at 1.0 and answers status 1
// with the curve point, or status 2 with zero coordinates when the list is
// empty. Every request yields exactly one response. An append is answered
// without leaving the idle state. In an evaluation of N points each axis has
// one interpolation lane (subtract, multiply, add, one stage each) that runs
// all N*(N-1)/2 steps in turn, fed by point stores with one read and one
// write port each, and every level opens with a state that reads its first
// point. One request is worked on at a time; a new request of any kind is
// taken no earlier than the edge at which the previous response leaves the
// output register, so a response held off by the consumer stalls the input.

module bezier_curve_eval_core #(
  parameter int unsigned MAX_POINTS = bce_pkg::MAX_POINTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request side
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bce_pkg::bce_req_t in_req_i,
  // response side
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bce_pkg::bce_rsp_t      out_rsp_o
);

  import bce_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  bce_cmd_t      cmd;      // per-cycle datapath commands
  logic [AW-1:0] rd_addr;  // shared read address of both stores
  logic [AW-1:0] wr_addr;  // shared write address of both stores

  // sequencer: point count, level and step counters, response valid
  bce_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_i       (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr)
  );

  // datapath: control and work stores, interpolation lanes, response register
  bce_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .req_i     (in_req_i),
    .rsp_o     (out_rsp_o)
  );

endmodule

`default_nettype wire
